// ----- hw/rtl/lzssfg_pkg.sv -----
// Package for the LZSS flag-group decompressor.
// Holds the beat types, phase and state encodings and status codes.
// No dependencies.
package lzssfg_pkg;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_input;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
        logic       last_of_run;
    } t_out_beat;

    typedef enum logic [3:0] {
        PH_FLAG = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_TLO  = 4'b0100,
        PH_THI  = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COPY = 4'b0010,
        S_STAT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_SHORT = 3'd1;
    localparam logic [2:0] STAT_DIST  = 3'd2;
    localparam logic [2:0] STAT_LONG  = 3'd3;
    localparam logic [2:0] STAT_STRAY = 3'd4;
    localparam logic [2:0] STAT_TRAIL = 3'd5;

    localparam int         LEN_W      = 24;
    localparam int         DIST_W     = 12;
    localparam logic [3:0] GROUP_SIZE = 4'd8;
    localparam logic [4:0] MIN_MATCH  = 5'd3;

endpackage

// ----- hw/rtl/lzss_flag_group_decompressor.sv -----
// LZSS flag-group decompressor top level with its history memory.
// Depends on lzssfg_pkg for beat types, encodings and status codes.
//
// Flag bytes, literals and low token bytes are taken while the decoder is idle.
// A match token's high byte starts a copy in which each output byte is one read
// and one write of the history memory; the history read is registered and a
// distance of one is served by forwarding the last byte. Input is stalled
// meanwhile. A status that follows data is sent from its own state after it.
// The history memory is not cleared after reset and needs no clearing pass.
// After the end-of-stream status every further input beat is taken and dropped
// until reset. A result waits in the output register while the output is stalled,
// and decoding pauses until that beat is taken.
module lzss_flag_group_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lzssfg_pkg::t_in_beat i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lzssfg_pkg::t_out_beat o_out_data,
    input  logic                 i_cfg_we,
    input  logic [23:0]          i_cfg_wdata
);
    import lzssfg_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int DW = ((AW > DIST_W) ? AW : DIST_W) + 1;

    logic [7:0]        r_hist [WINDOW_DEPTH];
    logic [7:0]        r_rd_data;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_exp;
    logic [LEN_W-1:0]  r_prod, n_prod;
    logic [7:0]        r_flags, n_flags;
    logic [3:0]        r_pos, n_pos;
    logic [7:0]        r_tlo, n_tlo;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_src, n_src;
    logic [4:0]        r_len, n_len;
    logic              r_last, n_last;
    logic              r_dist_one, n_dist_one;
    logic              r_use_fwd, n_use_fwd;
    logic [7:0]        r_last_byte, n_last_byte;
    logic [2:0]        r_stat, n_stat;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic              out_free;
    logic              in_acc;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_ptr_inc;
    logic [AW-1:0]     src_inc;
    logic [AW-1:0]     src_first;
    logic [DW-1:0]     src_diff;
    logic [DIST_W-1:0] tok_dist;
    logic [4:0]        mlen;
    logic              dist_bad;
    logic              len_bad;
    logic [7:0]        copy_byte;
    logic [LEN_W-1:0]  prod_inc;
    logic [3:0]        adv_pos;
    logic              adv_last;
    logic              adv_stat_en;
    logic [2:0]        adv_stat;
    t_phase            adv_phase;
    logic [7:0]        rest_flags;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(((r_state == S_IDLE) && out_free) || (r_state == S_DONE));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign wr_ptr_inc = (r_wr_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign src_inc    = (r_src == AW'(WINDOW_DEPTH - 1)) ? '0 : r_src + 1'b1;
    assign prod_inc   = r_prod + 1'b1;

    assign tok_dist = {i_in_data.packed_byte, r_tlo[7:4]};
    assign mlen     = {1'b0, r_tlo[3:0]} + MIN_MATCH;
    assign dist_bad = (tok_dist == '0) || (32'(tok_dist) >= WINDOW_DEPTH) ||
                      (LEN_W'(tok_dist) > r_prod);
    assign len_bad  = LEN_W'(mlen) > (r_exp - r_prod);
    assign src_diff = DW'(r_wr_ptr) - DW'(tok_dist);
    assign src_first = src_diff[DW-1] ? AW'(src_diff + DW'(WINDOW_DEPTH)) : AW'(src_diff);
    assign copy_byte = r_use_fwd ? r_last_byte : r_rd_data;

    // End-of-item bookkeeping shared by literals and the last byte of a match.
    assign adv_pos    = r_pos + 1'b1;
    assign adv_last   = (r_state == S_COPY) ? r_last : i_in_data.final_input;
    assign rest_flags = r_flags >> adv_pos;

    always_comb begin
        adv_stat_en = 1'b0;
        adv_stat    = STAT_OK;
        adv_phase   = PH_FLAG;
        if (prod_inc >= r_exp) begin
            if ((adv_pos < GROUP_SIZE) && (rest_flags != '0)) begin
                adv_stat_en = 1'b1;
                adv_stat    = STAT_STRAY;
            end else if (adv_last) begin
                adv_stat_en = 1'b1;
                adv_stat    = STAT_OK;
            end
        end else begin
            if (adv_pos >= GROUP_SIZE) begin
                adv_phase = PH_FLAG;
            end else if (rest_flags[0]) begin
                adv_phase = PH_TLO;
            end else begin
                adv_phase = PH_LIT;
            end
            if (adv_last) begin
                adv_stat_en = 1'b1;
                adv_stat    = STAT_SHORT;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_prod      = r_prod;
        n_flags     = r_flags;
        n_pos       = r_pos;
        n_tlo       = r_tlo;
        n_wr_ptr    = r_wr_ptr;
        n_src       = r_src;
        n_len       = r_len;
        n_last      = r_last;
        n_dist_one  = r_dist_one;
        n_use_fwd   = r_use_fwd;
        n_last_byte = r_last_byte;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = i_in_data.packed_byte;
        mem_re      = 1'b0;
        rd_addr     = src_first;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out.out_byte    = '0;
                    n_out.is_status   = 1'b1;
                    n_out.last_of_run = 1'b1;
                    if (r_prod >= r_exp) begin
                        n_out_valid  = 1'b1;
                        n_out.status = STAT_TRAIL;
                        n_state      = S_DONE;
                    end else begin
                        unique case (r_phase)
                            PH_FLAG: begin
                                n_flags = i_in_data.packed_byte;
                                n_pos   = '0;
                                n_phase = i_in_data.packed_byte[0] ? PH_TLO : PH_LIT;
                                if (i_in_data.final_input) begin
                                    n_out_valid  = 1'b1;
                                    n_out.status = STAT_SHORT;
                                    n_state      = S_DONE;
                                end
                            end
                            PH_LIT: begin
                                mem_we            = 1'b1;
                                mem_wdata         = i_in_data.packed_byte;
                                n_wr_ptr          = wr_ptr_inc;
                                n_prod            = prod_inc;
                                n_pos             = adv_pos;
                                n_phase           = adv_phase;
                                n_out_valid       = 1'b1;
                                n_out.out_byte    = i_in_data.packed_byte;
                                n_out.is_status   = 1'b0;
                                n_out.status      = STAT_OK;
                                n_out.last_of_run = !adv_stat_en;
                                n_stat            = adv_stat;
                                if (adv_stat_en) begin
                                    n_state = S_STAT;
                                end
                            end
                            PH_TLO: begin
                                n_tlo   = i_in_data.packed_byte;
                                n_phase = PH_THI;
                                if (i_in_data.final_input) begin
                                    n_out_valid  = 1'b1;
                                    n_out.status = STAT_SHORT;
                                    n_state      = S_DONE;
                                end
                            end
                            PH_THI: begin
                                if (dist_bad) begin
                                    n_out_valid  = 1'b1;
                                    n_out.status = STAT_DIST;
                                    n_state      = S_DONE;
                                end else if (len_bad) begin
                                    n_out_valid  = 1'b1;
                                    n_out.status = STAT_LONG;
                                    n_state      = S_DONE;
                                end else begin
                                    mem_re     = 1'b1;
                                    rd_addr    = src_first;
                                    n_src      = src_first;
                                    n_len      = mlen;
                                    n_last     = i_in_data.final_input;
                                    n_dist_one = (tok_dist == DIST_W'(1));
                                    n_use_fwd  = 1'b0;
                                    n_state    = S_COPY;
                                end
                            end
                            default: begin
                                n_phase = PH_FLAG;
                            end
                        endcase
                    end
                end
            end
            S_COPY: begin
                if (out_free) begin
                    mem_we            = 1'b1;
                    mem_wdata         = copy_byte;
                    n_wr_ptr          = wr_ptr_inc;
                    n_prod            = prod_inc;
                    n_last_byte       = copy_byte;
                    n_use_fwd         = r_dist_one;
                    n_len             = r_len - 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.out_byte    = copy_byte;
                    n_out.is_status   = 1'b0;
                    n_out.status      = STAT_OK;
                    n_out.last_of_run = 1'b0;
                    if (r_len == 5'd1) begin
                        n_pos             = adv_pos;
                        n_phase           = adv_phase;
                        n_stat            = adv_stat;
                        n_out.last_of_run = !adv_stat_en;
                        n_state           = adv_stat_en ? S_STAT : S_IDLE;
                    end else begin
                        mem_re  = 1'b1;
                        rd_addr = src_inc;
                        n_src   = src_inc;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_byte    = '0;
                    n_out.is_status   = 1'b1;
                    n_out.status      = r_stat;
                    n_out.last_of_run = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_wr_ptr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FLAG;
            r_exp       <= '0;
            r_prod      <= '0;
            r_flags     <= '0;
            r_pos       <= GROUP_SIZE;
            r_tlo       <= '0;
            r_wr_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_prod      <= n_prod;
            r_flags     <= n_flags;
            r_pos       <= n_pos;
            r_tlo       <= n_tlo;
            r_wr_ptr    <= n_wr_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_len       <= n_len;
        r_last      <= n_last;
        r_dist_one  <= n_dist_one;
        r_use_fwd   <= n_use_fwd;
        r_last_byte <= n_last_byte;
        r_stat      <= n_stat;
        r_out       <= n_out;
    end

`ifndef SYNTHESIS
    a_copy_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_len != '0))
        else $error("match copy running with no bytes left");

    a_status_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_status) |-> (r_state == S_DONE))
        else $error("status beat shown while stream still decoding");

    a_done_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> !r_out_valid)
        else $error("result beat produced after end of stream");
`endif

endmodule
